[rtl/tcw_pkg.sv]
`timescale 1ns / 1ps

package tcw_pkg;

	// Command codes
	localparam logic [1:0] CMD_PUT   = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// Character codes with special meaning
	localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
	localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
	localparam logic [7:0] CHAR_SPACE     = 8'h20;

	localparam logic [7:0] ATTR_RESET = 8'h07;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  char_code;
		logic [10:0] cell_index;
	} item_t;

	typedef struct packed {
		logic [10:0] cursor_pos;
		logic [15:0] cell_value;
	} res_t;

	// Sequencer status toward the channel logic
	typedef struct packed {
		logic idle;
		logic res_valid;
	} seq_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RDWAIT,
		ST_SCROLL,
		ST_FILL,
		ST_DONE
	} seq_state_t;

endpackage

[rtl/tcw_if.sv]
`timescale 1ns / 1ps

interface tcw_req_if import tcw_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [7:0]  char_code;
	logic [10:0] cell_index;

	modport source (output valid, cmd, char_code, cell_index, input ready);
	modport sink (input valid, cmd, char_code, cell_index, output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [10:0] cursor_pos;
	logic [15:0] cell_value;

	modport source (output valid, cursor_pos, cell_value, input ready);
	modport sink (input valid, cursor_pos, cell_value, output ready);
endinterface

interface tcw_cfg_if import tcw_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] text_attribute;

	modport source (output valid, text_attribute, input ready);
	modport sink (input valid, text_attribute, output ready);
endinterface

[rtl/tcw_ram.sv]
`timescale 1ns / 1ps

module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/tcw_seq.sv]
`timescale 1ns / 1ps

module tcw_seq import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  item_t                               item,
	input  logic [7:0]                          attr,
	input  logic                                res_take,
	output seq_stat_t                           stat,
	output res_t                                res,
	output logic                                mem_we,
	output logic [$clog2(COLUMNS*ROWS)-1:0]     mem_waddr,
	output logic [15:0]                         mem_wdata,
	output logic [$clog2(COLUMNS*ROWS)-1:0]     mem_raddr,
	input  logic [15:0]                         mem_rdata
);

	localparam int CellCount = COLUMNS * ROWS;
	localparam int AddrW     = $clog2(CellCount);
	localparam int CurW      = $clog2(CellCount + 1);
	localparam int ColW      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int CopyCount = CellCount - COLUMNS;

	localparam logic [AddrW-1:0] LastCell = AddrW'(CellCount - 1);
	localparam logic [AddrW-1:0] CopyEnd  = AddrW'(CopyCount);
	localparam logic [AddrW-1:0] RowStep  = AddrW'(COLUMNS);
	localparam logic [ColW-1:0]  ColLast  = ColW'(COLUMNS - 1);
	localparam logic [CurW-1:0]  ColsCur  = CurW'(COLUMNS);
	localparam logic [CurW-1:0]  CellsCur = CurW'(CellCount);

	seq_state_t state_q, state_d;
	item_t      item_q, item_d;
	logic [AddrW-1:0] cur_q, cur_d;
	logic [ColW-1:0]  col_q, col_d;
	logic [AddrW-1:0] ptr_q, ptr_d;
	logic [15:0]      val_q, val_d;
	logic             pend_s1, pend_d;
	logic [AddrW-1:0] addr_s1, addr_d;
	logic [CurW-1:0]  nxt;
	logic [15:0]      blank;

	assign blank = {attr, CHAR_SPACE};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cur_q   <= '0;
			col_q   <= '0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			cur_q   <= cur_d;
			col_q   <= col_d;
			pend_s1 <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		item_q  <= item_d;
		ptr_q   <= ptr_d;
		val_q   <= val_d;
		addr_s1 <= addr_d;
	end

	always_comb begin
		state_d   = state_q;
		item_d    = item_q;
		cur_d     = cur_q;
		col_d     = col_q;
		ptr_d     = ptr_q;
		val_d     = val_q;
		pend_d    = 1'b0;
		addr_d    = ptr_q;
		nxt       = CurW'(cur_q);
		mem_raddr = ptr_q + RowStep;
		mem_we    = pend_s1;
		mem_waddr = addr_s1;
		mem_wdata = mem_rdata;

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					item_d  = item;
					val_d   = '0;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_DONE;
				unique case (item_q.cmd)
					CMD_PUT: begin
						priority if (item_q.char_code == CHAR_NEWLINE) begin
							nxt   = CurW'(cur_q) - CurW'(col_q) + ColsCur;
							col_d = '0;
						end else if (item_q.char_code == CHAR_BACKSPACE) begin
							if (cur_q != '0) begin
								nxt       = CurW'(cur_q - 1'b1);
								col_d     = (col_q == '0) ? ColLast : col_q - 1'b1;
								mem_we    = 1'b1;
								mem_waddr = cur_q - 1'b1;
								mem_wdata = blank;
							end
						end else begin
							nxt       = CurW'(cur_q) + 1'b1;
							col_d     = (col_q == ColLast) ? '0 : col_q + 1'b1;
							mem_we    = 1'b1;
							mem_waddr = cur_q;
							mem_wdata = {attr, item_q.char_code};
						end
						// Passing the end: scroll up one row
						if (nxt >= CellsCur) begin
							cur_d   = CopyEnd;
							col_d   = '0;
							ptr_d   = '0;
							state_d = ST_SCROLL;
						end else begin
							cur_d = AddrW'(nxt);
						end
					end
					CMD_CLEAR: begin
						cur_d   = '0;
						col_d   = '0;
						ptr_d   = '0;
						state_d = ST_FILL;
					end
					CMD_READ: begin
						if (32'(item_q.cell_index) < CellCount) begin
							mem_raddr = AddrW'(item_q.cell_index);
							state_d   = ST_RDWAIT;
						end
					end
					default: begin
					end
				endcase
			end
			ST_RDWAIT: begin
				val_d   = mem_rdata;
				state_d = ST_DONE;
			end
			ST_SCROLL: begin
				// Read row below now, write it one row up next cycle
				if (ptr_q != CopyEnd) begin
					pend_d = 1'b1;
					ptr_d  = ptr_q + 1'b1;
				end else begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q;
				mem_wdata = blank;
				if (ptr_q == LastCell) begin
					state_d = ST_DONE;
				end else begin
					ptr_d = ptr_q + 1'b1;
				end
			end
			ST_DONE: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign stat.idle      = (state_q == ST_IDLE);
	assign stat.res_valid = (state_q == ST_DONE);
	assign res.cursor_pos = 11'(cur_q);
	assign res.cell_value = val_q;

	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cur_q) < CellCount)
		else $error("cursor outside the store");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) < COLUMNS)
		else $error("column counter outside the row");

	a_copy_only_in_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> state_q == ST_SCROLL)
		else $error("pending copy write outside scroll");

	a_no_write_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_DONE || state_q == ST_RDWAIT) |-> !mem_we)
		else $error("store write while no work is in progress");

endmodule

[rtl/text_console_writer.sv]
`timescale 1ns / 1ps

// Text console engine: a store of COLUMNS x ROWS 16-bit cells (attribute over
// character) plus a cursor. Commands arrive on req (put character, clear,
// read cell); each produces exactly one transfer on rsp with the cursor after
// the command and, for a read, the cell. cfg sets the attribute byte (reset
// 0x07); write it only while the block is idle. Items run one at a time
// through a sequencer around a single-port-write, single-port-read RAM with a
// registered read. A put, backspace, newline, unused command or out-of-range
// read passes through an execute state to the result; an in-range read adds
// a wait state for the RAM data. A put or newline that passes the last cell
// scrolls: one RAM copy per cell for COLUMNS*(ROWS-1) cells, a drain step for
// the last copy, then blanking of the bottom row's COLUMNS cells. Clear blanks
// every cell, one per cycle. The store has no reset;
// a read of a cell never written or cleared returns undefined data. The
// output register lets the next command be accepted while a result waits.
module text_console_writer import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic      clk,
	input  logic      arst_n,
	tcw_req_if.sink   req,
	tcw_rsp_if.source rsp,
	tcw_cfg_if.sink   cfg
);

	localparam int CellCount = COLUMNS * ROWS;
	localparam int AddrW     = $clog2(CellCount);

	logic [7:0]       attr_q;
	seq_stat_t        stat;
	res_t             res;
	res_t             res_q;
	logic             full_q;
	logic             res_take;
	logic             start;
	item_t            item;
	logic             mem_we;
	logic [AddrW-1:0] mem_waddr;
	logic [15:0]      mem_wdata;
	logic [AddrW-1:0] mem_raddr;
	logic [15:0]      mem_rdata;

	// Attribute register: always ready; the user must write it only while idle, the block does not enforce it
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (cfg.valid) begin
			attr_q <= cfg.text_attribute;
		end
	end

	// Take a new command only when the sequencer is idle
	assign req.ready      = stat.idle;
	assign start          = req.valid && stat.idle;
	assign item.cmd       = req.cmd;
	assign item.char_code = req.char_code;
	assign item.cell_index = req.cell_index;

	// Output register: load when empty or being drained in the same cycle
	assign res_take = stat.res_valid && (!full_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (res_take) begin
			full_q <= 1'b1;
		end else if (rsp.ready) begin
			full_q <= 1'b0;
		end
	end

	// Hold the payload while a transfer is pending
	always_ff @(posedge clk) begin
		if (res_take) begin
			res_q <= res;
		end
	end

	assign rsp.valid      = full_q;
	assign rsp.cursor_pos = res_q.cursor_pos;
	assign rsp.cell_value = res_q.cell_value;

	tcw_seq #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.attr      (attr_q),
		.res_take  (res_take),
		.stat      (stat),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	tcw_ram #(
		.WIDTH (16),
		.DEPTH (CellCount)
	) u_cells (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

[verif/text_console_writer_test.sv]
`timescale 1ns / 1ps

// Stimulus runs as a directed pass followed by three random phases. Each
// phase uses a different idle pattern and a different attribute setting.
// A behavioral model of the console tracks the cursor, the cell store and,
// for each cell, whether it has been written since reset. The model runs
// at each accepted request. Each response transfer is checked against the
// oldest report still due.
module text_console_writer_test;
	import tcw_pkg::*;

	localparam int COLS       = 80;
	localparam int NROWS      = 25;
	localparam int CELLS      = COLS * NROWS;
	localparam int LAST_ROW   = CELLS - COLS;
	localparam int INDEX_TOP  = 2047;
	localparam int MAX_PRINTS = 100;

	// The package names no code for the fourth command; the block must treat it as a no-op
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic clk;
	logic arst_n;

	tcw_req_if req_ch ();
	tcw_rsp_if rsp_ch ();
	tcw_cfg_if cfg_ch ();

	text_console_writer #(
		.COLUMNS(COLS),
		.ROWS   (NROWS)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch),
		.cfg   (cfg_ch)
	);

	// Console model state: mirrors what the block should hold
	logic [15:0] screen_model [CELLS];
	bit          cell_written [CELLS];
	int          cursor_model;
	logic [7:0]  attr_model;

	// Cursor reports (and read data) still owed by the block, oldest first
	res_t        due_reports [$];

	int          mismatch_count;
	int          send_idle_pct;
	int          recv_stall_pct;

	// Clock: 10 ns period
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Hold the run to a fixed budget; a hang ends here
	initial begin
		#20_000_000;
		$display("text_console_writer_test: FAIL");
		$finish;
	end

	// Stall the response channel at random, at the current stall rate
	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic flag_mismatch(input string what);
		if (mismatch_count < MAX_PRINTS)
			$display("[%0t] mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	// Compare every response transfer with the oldest report still due.
	// Outputs and ready are both updated by nonblocking assignments, so the
	// values seen here are the ones that met at this edge.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (due_reports.size() == 0) begin
				flag_mismatch($sformatf("unexpected transfer cursor=%0d cell=%h",
					rsp_ch.cursor_pos, rsp_ch.cell_value));
			end else begin
				want = due_reports.pop_front();
				if (rsp_ch.cursor_pos !== want.cursor_pos)
					flag_mismatch($sformatf("cursor_pos got %0d want %0d",
						rsp_ch.cursor_pos, want.cursor_pos));
				if (rsp_ch.cell_value !== want.cell_value)
					flag_mismatch($sformatf("cell_value got %h want %h (cursor %0d)",
						rsp_ch.cell_value, want.cell_value, want.cursor_pos));
			end
		end
	end

	function automatic logic [15:0] blank_glyph();
		return {attr_model, CHAR_SPACE};
	endfunction

	// Advance the console model by one command and queue the report it owes
	task automatic apply_console_command(input item_t cmd_item);
		res_t report;
		int   c;
		report.cell_value = '0;
		case (cmd_item.cmd)
			CMD_PUT: begin
				if (cmd_item.char_code == CHAR_NEWLINE) begin
					cursor_model = cursor_model + COLS - (cursor_model % COLS);
				end else if (cmd_item.char_code == CHAR_BACKSPACE) begin
					// Backspace at home leaves everything alone
					if (cursor_model > 0) begin
						cursor_model--;
						screen_model[cursor_model] = blank_glyph();
						cell_written[cursor_model] = 1'b1;
					end
				end else begin
					if (cursor_model < CELLS) begin
						screen_model[cursor_model] = {attr_model, cmd_item.char_code};
						cell_written[cursor_model] = 1'b1;
					end
					cursor_model++;
				end
				// Past the last cell: shift every row up, blank the bottom row
				if (cursor_model >= CELLS) begin
					for (c = 0; c < LAST_ROW; c++) begin
						screen_model[c] = screen_model[c + COLS];
						cell_written[c] = cell_written[c + COLS];
					end
					for (c = LAST_ROW; c < CELLS; c++) begin
						screen_model[c] = blank_glyph();
						cell_written[c] = 1'b1;
					end
					cursor_model = LAST_ROW;
				end
			end
			CMD_CLEAR: begin
				for (c = 0; c < CELLS; c++) begin
					screen_model[c] = blank_glyph();
					cell_written[c] = 1'b1;
				end
				cursor_model = 0;
			end
			CMD_READ: begin
				// Out-of-range reads return zero and change nothing
				if (cmd_item.cell_index < CELLS)
					report.cell_value = screen_model[cmd_item.cell_index];
			end
			default: begin
				// Unused command: report the cursor only
			end
		endcase
		report.cursor_pos = cursor_model[10:0];
		due_reports.push_back(report);
	endtask

	// Send one request: idle first at the current rate, then hold valid
	// until the transfer. Valid stays high on return so back-to-back
	// requests keep it asserted.
	task automatic send_command(input logic [1:0] cmd, input logic [7:0] ch,
			input logic [10:0] idx);
		item_t cmd_item;
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.cmd        <= cmd;
		req_ch.char_code  <= ch;
		req_ch.cell_index <= idx;
		do @(posedge clk); while (!req_ch.ready);
		cmd_item.cmd        = cmd;
		cmd_item.char_code  = ch;
		cmd_item.cell_index = idx;
		apply_console_command(cmd_item);
	endtask

	// Drop valid and hold off until every owed report has come back
	task automatic wait_reports_drained();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (due_reports.size() != 0);
	endtask

	// Only called with the block idle
	task automatic write_attribute(input logic [7:0] value);
		cfg_ch.valid          <= 1'b1;
		cfg_ch.text_attribute <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		attr_model = value;
	endtask

	// Pick a read address that never touches a cell still undefined since
	// reset; fall back on the out-of-range window above the store
	function automatic logic [10:0] pick_read_index();
		int idx;
		if ($urandom_range(9) == 0)
			return 11'($urandom_range(INDEX_TOP, CELLS));
		for (int tries = 0; tries < 8; tries++) begin
			idx = $urandom_range(CELLS - 1);
			if (cell_written[idx])
				return 11'(idx);
		end
		return 11'($urandom_range(INDEX_TOP, CELLS));
	endfunction

	// Extremes of each field, every command, backspace at home, and reads
	// past the end of the store
	task automatic test_directed();
		// Attribute still at its reset value; the store is undefined,
		// so read only cells written here
		send_command(CMD_PUT, 8'h41, 11'd0);
		send_command(CMD_READ, 8'h00, 11'd0);
		send_command(CMD_PUT, CHAR_BACKSPACE, 11'd0);
		send_command(CMD_PUT, CHAR_BACKSPACE, INDEX_TOP[10:0]);
		send_command(CMD_READ, 8'hFF, 11'd0);
		send_command(CMD_PUT, 8'h00, 11'd0);
		send_command(CMD_PUT, 8'hFF, INDEX_TOP[10:0]);
		send_command(CMD_READ, 8'h00, 11'd1);
		send_command(CMD_PUT, CHAR_NEWLINE, 11'd0);
		send_command(CMD_UNUSED, 8'hFF, INDEX_TOP[10:0]);
		send_command(CMD_READ, 8'h00, INDEX_TOP[10:0]);
		send_command(CMD_READ, 8'h00, 11'(CELLS));
		wait_reports_drained();

		// All-ones attribute, then clear so the whole store is defined
		write_attribute(8'hFF);
		send_command(CMD_CLEAR, 8'h55, 11'd5);
		send_command(CMD_READ, 8'h00, 11'(CELLS - 1));
		send_command(CMD_PUT, 8'h7E, 11'd0);
		send_command(CMD_PUT, CHAR_NEWLINE, 11'd0);
		send_command(CMD_READ, 8'h00, 11'd0);
		wait_reports_drained();

		// All-zero attribute: backspace blanks with it
		write_attribute(8'h00);
		send_command(CMD_PUT, CHAR_BACKSPACE, 11'd0);
		send_command(CMD_READ, 8'h00, 11'(COLS - 1));
		send_command(CMD_PUT, 8'h5A, 11'd0);
		send_command(CMD_READ, 8'h00, 11'(COLS - 1));
		wait_reports_drained();
	endtask

	// Mostly text and newlines so the cursor walks down and scrolls; reads
	// of defined cells, rare clears, and some unused commands as noise.
	// Newlines thin out on the bottom row, where each one costs a scroll.
	task automatic test_random(input int count, input int idle_pct,
			input int stall_pct, input logic [7:0] attr);
		int          pick;
		int          nl_pct;
		logic [7:0]  ch;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		write_attribute(attr);
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(999);
			if (pick < 7) begin
				send_command(CMD_CLEAR, 8'($urandom), 11'($urandom));
			end else if (pick < 30) begin
				send_command(CMD_UNUSED, 8'($urandom), 11'($urandom));
			end else if (pick < 230) begin
				send_command(CMD_READ, 8'($urandom), pick_read_index());
			end else begin
				nl_pct = (cursor_model < LAST_ROW) ? 30 : 3;
				pick   = $urandom_range(99);
				if (pick < nl_pct)
					ch = CHAR_NEWLINE;
				else if (pick < nl_pct + 8)
					ch = CHAR_BACKSPACE;
				else
					ch = 8'($urandom_range(255));
				send_command(CMD_PUT, ch, 11'($urandom));
			end
		end
		// Pause until the block has answered everything
		wait_reports_drained();
	endtask

	initial begin
		// Drive every input to a known value before the first edge
		arst_n                = 1'b0;
		req_ch.valid          = 1'b0;
		req_ch.cmd            = CMD_PUT;
		req_ch.char_code      = '0;
		req_ch.cell_index     = '0;
		rsp_ch.ready          = 1'b0;
		cfg_ch.valid          = 1'b0;
		cfg_ch.text_attribute = ATTR_RESET;

		cursor_model   = 0;
		attr_model     = ATTR_RESET;
		mismatch_count = 0;
		send_idle_pct  = 18;
		recv_stall_pct = 65;
		for (int c = 0; c < CELLS; c++) begin
			screen_model[c] = '0;
			cell_written[c] = 1'b0;
		end

		// Hold reset, then release it on an edge
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(700, 18, 65, 8'h0F);
		test_random(700, 65, 18, 8'h0E);
		test_random(600, 0, 0, 8'($urandom));

		// Let any stray transfer show up before judging
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && due_reports.size() == 0) begin
			$display("text_console_writer_test: PASS");
		end else begin
			$display("text_console_writer_test: FAIL");
		end
		$finish;
	end

endmodule

[files.f]
rtl/tcw_pkg.sv
rtl/tcw_if.sv
rtl/tcw_ram.sv
rtl/tcw_seq.sv
rtl/text_console_writer.sv
verif/text_console_writer_test.sv
